@@ rtl/core/lru_frame_replacement_defines.svh @@
// Assertion macros shared by the checker of the LRU frame replacement block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef LRU_FRAME_REPLACEMENT_DEFINES_SVH
`define LRU_FRAME_REPLACEMENT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LFR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lfr_pkg.sv @@
// Shared types and constants of the LRU frame replacement block.
// Depends on nothing; the RTL files that use it refer to it by scoped names.
package lfr_pkg;

    localparam int NUM_FRAMES = 256;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int IDX_CHK_W  = 14;

    localparam logic CMD_REFERENCE = 1'b0;
    localparam logic CMD_EVICT     = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] frame_index;
    } lfr_in_t;

    typedef struct packed {
        logic [7:0] victim_frame;
        logic       victim_valid;
        logic       empty_error;
    } lfr_out_t;

    typedef struct packed {
        logic               wr_en;
        logic [FRAME_W-1:0] wr_addr;
        logic [FRAME_W-1:0] wr_data;
    } lfr_wr_t;

    typedef struct packed {
        logic [FRAME_W-1:0] rd_addr;
        lfr_wr_t            next_wr;
        lfr_wr_t            prev_wr;
    } lfr_link_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_MOVE_HEAD,
        ST_UNLINK,
        ST_APPEND,
        ST_RESULT
    } lfr_state_t;

endpackage

@@ rtl/core/lfr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/lfr_ctrl.sv @@
// Sequencer of the LRU frame replacement block: head, tail, count, membership
// bits and the read-modify-write steps on the link RAMs. Depends on lfr_pkg.
module lfr_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lfr_pkg::lfr_in_t                s_payload,
    output lfr_pkg::lfr_link_req_t          link_req,
    input  logic [lfr_pkg::FRAME_W-1:0]     next_rdata,
    input  logic [lfr_pkg::FRAME_W-1:0]     prev_rdata,
    output logic                            res_valid,
    input  logic                            res_ready,
    output lfr_pkg::lfr_out_t               res
);

    lfr_pkg::lfr_state_t state_reg, state_next;

    logic [lfr_pkg::FRAME_W-1:0]    head_reg, head_next;
    logic [lfr_pkg::FRAME_W-1:0]    tail_reg, tail_next;
    logic [lfr_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [lfr_pkg::NUM_FRAMES-1:0] in_list_reg, in_list_next;
    logic [lfr_pkg::FRAME_W-1:0]    frame_reg, frame_next;
    lfr_pkg::lfr_out_t              res_reg, res_next;

    logic [lfr_pkg::FRAME_W-1:0] acc_frame;
    logic                        in_range;
    logic                        hit;
    logic                        count_zero;
    logic                        count_one;

    assign acc_frame  = lfr_pkg::FRAME_W'(s_payload.frame_index);
    assign in_range   = lfr_pkg::IDX_CHK_W'(s_payload.frame_index)
                        < lfr_pkg::IDX_CHK_W'(lfr_pkg::NUM_FRAMES);
    assign hit        = in_list_reg[acc_frame];
    assign count_zero = (count_reg == '0);
    assign count_one  = (count_reg == lfr_pkg::CNT_W'(1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lfr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_payload.command == lfr_pkg::CMD_EVICT) begin
                        if (count_zero || count_one) begin
                            state_next = lfr_pkg::ST_RESULT;
                        end else begin
                            state_next = lfr_pkg::ST_EVICT_RD;
                        end
                    end else if (!in_range || !hit || acc_frame == tail_reg) begin
                        state_next = lfr_pkg::ST_RESULT;
                    end else if (acc_frame == head_reg) begin
                        state_next = lfr_pkg::ST_MOVE_HEAD;
                    end else begin
                        state_next = lfr_pkg::ST_UNLINK;
                    end
                end
            end
            lfr_pkg::ST_EVICT_RD:  state_next = lfr_pkg::ST_RESULT;
            lfr_pkg::ST_MOVE_HEAD: state_next = lfr_pkg::ST_RESULT;
            lfr_pkg::ST_UNLINK:    state_next = lfr_pkg::ST_APPEND;
            lfr_pkg::ST_APPEND:    state_next = lfr_pkg::ST_RESULT;
            lfr_pkg::ST_RESULT: begin
                if (res_ready) begin
                    state_next = lfr_pkg::ST_IDLE;
                end
            end
            default: state_next = lfr_pkg::ST_IDLE;
        endcase
    end

    // Outputs, link RAM requests and register updates.
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        in_list_next = in_list_reg;
        frame_next   = frame_reg;
        res_next     = res_reg;
        link_req     = '0;
        link_req.rd_addr = (s_payload.command == lfr_pkg::CMD_EVICT) ? head_reg : acc_frame;
        s_ready      = (state_reg == lfr_pkg::ST_IDLE);
        res_valid    = (state_reg == lfr_pkg::ST_RESULT);

        case (state_reg)
            lfr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    frame_next = acc_frame;
                    res_next   = '0;
                    if (s_payload.command == lfr_pkg::CMD_EVICT) begin
                        if (count_zero) begin
                            res_next.empty_error = 1'b1;
                        end else begin
                            res_next.victim_frame = 8'(head_reg);
                            res_next.victim_valid = 1'b1;
                            if (count_one) begin
                                head_next              = '0;
                                tail_next              = '0;
                                in_list_next[head_reg] = 1'b0;
                                count_next             = count_reg - lfr_pkg::CNT_W'(1);
                            end
                        end
                    end else if (in_range && !hit) begin
                        // A new frame goes straight to the tail.
                        if (count_zero) begin
                            head_next = acc_frame;
                        end else begin
                            link_req.next_wr = '{wr_en: 1'b1, wr_addr: tail_reg,
                                                 wr_data: acc_frame};
                            link_req.prev_wr = '{wr_en: 1'b1, wr_addr: acc_frame,
                                                 wr_data: tail_reg};
                        end
                        tail_next               = acc_frame;
                        in_list_next[acc_frame] = 1'b1;
                        count_next              = count_reg + lfr_pkg::CNT_W'(1);
                    end
                end
            end
            lfr_pkg::ST_EVICT_RD: begin
                head_next              = next_rdata;
                in_list_next[head_reg] = 1'b0;
                count_next             = count_reg - lfr_pkg::CNT_W'(1);
            end
            lfr_pkg::ST_MOVE_HEAD: begin
                head_next        = next_rdata;
                link_req.next_wr = '{wr_en: 1'b1, wr_addr: tail_reg, wr_data: frame_reg};
                link_req.prev_wr = '{wr_en: 1'b1, wr_addr: frame_reg, wr_data: tail_reg};
                tail_next        = frame_reg;
            end
            lfr_pkg::ST_UNLINK: begin
                // Bridge the predecessor and successor of the moved frame.
                link_req.next_wr = '{wr_en: 1'b1, wr_addr: prev_rdata, wr_data: next_rdata};
                link_req.prev_wr = '{wr_en: 1'b1, wr_addr: next_rdata, wr_data: prev_rdata};
            end
            lfr_pkg::ST_APPEND: begin
                link_req.next_wr = '{wr_en: 1'b1, wr_addr: tail_reg, wr_data: frame_reg};
                link_req.prev_wr = '{wr_en: 1'b1, wr_addr: frame_reg, wr_data: tail_reg};
                tail_next        = frame_reg;
            end
            lfr_pkg::ST_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lfr_pkg::ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            in_list_reg <= '0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            in_list_reg <= in_list_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule

@@ rtl/core/lru_frame_replacement.sv @@
// Exact LRU frame replacement: a doubly linked list of frames in two link RAMs.
// Depends on lfr_pkg, lfr_ram and lfr_ctrl.
//
// The s_ channel takes one command per transfer: a reference to a frame, which
// moves it to the most recently used end, or an eviction, which removes and
// reports the least recently used frame. Every command gives exactly one
// transfer on the m_ channel; references report all-zero fields, and an
// eviction on an empty list reports empty_error.
// An insert, a reference to the most recent frame, an out-of-range frame or an
// eviction from a list of at most one frame goes straight to ST_RESULT; any
// other eviction passes through ST_EVICT_RD, a move of the oldest frame through
// ST_MOVE_HEAD, and a move from the middle through ST_UNLINK and ST_APPEND.
// A new command is taken only once the last one has left ST_RESULT. The steps
// are set by the link RAMs: a move reads both links of the frame, then patches
// its neighbors, then appends it, and each link RAM has one write port.
// Reset clears the list at once; the link RAMs need no clearing, as links are
// only read for frames whose links were written when they joined the list.
// The result sits in an output register, so a stalled receiver does not block
// the next command; only a further result waits until that register is taken.
module lru_frame_replacement (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lfr_pkg::lfr_in_t   s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output lfr_pkg::lfr_out_t  m_payload
);

    lfr_pkg::lfr_link_req_t          link_req;
    logic [lfr_pkg::FRAME_W-1:0]     next_rdata;
    logic [lfr_pkg::FRAME_W-1:0]     prev_rdata;
    logic                            res_valid;
    logic                            res_ready;
    lfr_pkg::lfr_out_t               res;

    logic                            m_valid_reg;
    lfr_pkg::lfr_out_t               m_payload_reg;

    // The sequencer owns the list order; the RAMs hold the successor and
    // predecessor of every listed frame.
    lfr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .link_req   (link_req),
        .next_rdata (next_rdata),
        .prev_rdata (prev_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    lfr_ram #(
        .WIDTH (lfr_pkg::FRAME_W),
        .DEPTH (lfr_pkg::NUM_FRAMES)
    ) u_next_ram (
        .aclk    (aclk),
        .wr_en   (link_req.next_wr.wr_en),
        .wr_addr (link_req.next_wr.wr_addr),
        .wr_data (link_req.next_wr.wr_data),
        .rd_addr (link_req.rd_addr),
        .rd_data (next_rdata)
    );

    lfr_ram #(
        .WIDTH (lfr_pkg::FRAME_W),
        .DEPTH (lfr_pkg::NUM_FRAMES)
    ) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (link_req.prev_wr.wr_en),
        .wr_addr (link_req.prev_wr.wr_addr),
        .wr_data (link_req.prev_wr.wr_data),
        .rd_addr (link_req.rd_addr),
        .rd_data (prev_rdata)
    );

    // The output register is free when empty or when its transfer completes.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_payload_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

@@ rtl/core/lfr_checker.sv @@
// Port-level checker of the LRU frame replacement block and its bind.
// Depends on lfr_pkg and lru_frame_replacement_defines.svh.
`include "lru_frame_replacement_defines.svh"

module lfr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input lfr_pkg::lfr_out_t m_payload
);

    // A stalled result holds its value.
    `LFR_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_payload), "result changed while stalled")

    // Commands are handled one at a time.
    `LFR_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready,
        "command accepted while another is in progress")

    // A victim and an empty-list error never come together.
    `LFR_ASSERT_SAME(a_flags_excl, aclk, aresetn, m_valid,
        !(m_payload.victim_valid && m_payload.empty_error), "victim and error both set")

    // Without a victim the frame field reads zero.
    `LFR_ASSERT_SAME(a_no_victim_zero, aclk, aresetn, m_valid && !m_payload.victim_valid,
        m_payload.victim_frame == 8'd0, "victim frame nonzero without a victim")

endmodule

bind lru_frame_replacement lfr_checker u_lfr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

@@ sim/tb_lru_frame_replacement.sv @@
// Self-checking testbench for lru_frame_replacement: directed rows, then random traffic.
// Depends on lfr_pkg and the lru_frame_replacement RTL; every transfer is checked
// against an in-bench model of the exact LRU list or a result typed in its row.
module tb_lru_frame_replacement;
    timeunit 1ns;
    timeprecision 1ps;

    import lfr_pkg::*;

    // The slowest correct run is far below this: about 780 commands, each with the
    // longest send gap, its pass through the block and the longest receive stall.
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_ITEMS = 750;
    localparam int CALM_ITEMS   = 100;
    localparam int DRAIN_CYCLES = 8;

    // One row of stimulus. When typed is set, the expected result is given in
    // the row itself; otherwise it comes from the list model below.
    typedef struct {
        logic       command;
        logic [7:0] frame_index;
        bit         typed;
        logic [7:0] want_victim;
        logic       want_valid;
        logic       want_error;
    } stim_row_t;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    lfr_in_t   s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    lfr_out_t  m_payload;

    lru_frame_replacement dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the LRU order. The list runs from lru_frame (oldest) to
    // mru_frame (newest); membership is held by is_listed alone, so a list
    // of one frame never links to itself.
    // ------------------------------------------------------------------
    logic [7:0] successor_of   [NUM_FRAMES];
    logic [7:0] predecessor_of [NUM_FRAMES];
    bit         is_listed      [NUM_FRAMES];
    logic [7:0] lru_frame    = '0;
    logic [7:0] mru_frame    = '0;
    int         listed_count = 0;

    function automatic void link_at_tail(input logic [7:0] frame);
        if (listed_count == 0) begin
            lru_frame = frame;
        end else begin
            successor_of[mru_frame] = frame;
            predecessor_of[frame]   = mru_frame;
        end
        mru_frame = frame;
    endfunction

    // Applies one command to the model and returns the transfer it must produce.
    function automatic lfr_out_t advance_lru_order(input lfr_in_t cmd);
        lfr_out_t   report;
        logic [7:0] frame;
        logic [7:0] before_frame;
        logic [7:0] after_frame;
        report = '0;
        if (cmd.command == CMD_EVICT) begin
            if (listed_count == 0) begin
                // Nothing to evict: flag it and leave the list alone.
                report.empty_error = 1'b1;
                return report;
            end
            frame = lru_frame;
            if (listed_count > 1) begin
                lru_frame = successor_of[frame];
            end else begin
                lru_frame = '0;
                mru_frame = '0;
            end
            is_listed[frame] = 1'b0;
            listed_count--;
            report.victim_frame = frame;
            report.victim_valid = 1'b1;
            return report;
        end
        if (int'(cmd.frame_index) >= NUM_FRAMES) begin
            return report;
        end
        frame = cmd.frame_index;
        if (!is_listed[frame]) begin
            link_at_tail(frame);
            is_listed[frame] = 1'b1;
            listed_count++;
        end else if (frame == mru_frame) begin
            // Already the newest frame; the order stays as it is.
        end else if (frame == lru_frame) begin
            lru_frame = successor_of[frame];
            link_at_tail(frame);
        end else begin
            before_frame = predecessor_of[frame];
            after_frame  = successor_of[frame];
            successor_of[before_frame] = after_frame;
            predecessor_of[after_frame] = before_frame;
            link_at_tail(frame);
        end
        return report;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows. References always report all-zero fields and an
    // eviction on an empty list reports only empty_error, so those are
    // typed in; the victims of evictions come from the model.
    // ------------------------------------------------------------------
    stim_row_t directed_rows [23] = '{
        '{CMD_EVICT,     8'h00, 1'b1, 8'h00, 1'b0, 1'b1},  // evict right after reset
        '{CMD_REFERENCE, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
        '{CMD_REFERENCE, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0},  // the only frame again
        '{CMD_EVICT,     8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},  // last frame leaves
        '{CMD_EVICT,     8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
        '{CMD_REFERENCE, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0},
        '{CMD_REFERENCE, 8'hAA, 1'b1, 8'h00, 1'b0, 1'b0},
        '{CMD_REFERENCE, 8'h55, 1'b1, 8'h00, 1'b0, 1'b0},
        '{CMD_REFERENCE, 8'h01, 1'b1, 8'h00, 1'b0, 1'b0},
        '{CMD_REFERENCE, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0},  // oldest frame moves up
        '{CMD_REFERENCE, 8'h55, 1'b1, 8'h00, 1'b0, 1'b0},  // frame from the middle
        '{CMD_REFERENCE, 8'h01, 1'b1, 8'h00, 1'b0, 1'b0},  // another middle frame
        '{CMD_REFERENCE, 8'h01, 1'b1, 8'h00, 1'b0, 1'b0},  // already the newest
        '{CMD_EVICT,     8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_EVICT,     8'h7F, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_EVICT,     8'h80, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_REFERENCE, 8'h80, 1'b1, 8'h00, 1'b0, 1'b0},
        '{CMD_EVICT,     8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_EVICT,     8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_EVICT,     8'h00, 1'b1, 8'h00, 1'b0, 1'b1},  // emptied again
        '{CMD_REFERENCE, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
        '{CMD_EVICT,     8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_EVICT,     8'h00, 1'b1, 8'h00, 1'b0, 1'b1}
    };

    stim_row_t stimulus_rows [$];
    lfr_out_t  victim_reports_due [$];
    stim_row_t presented_row;
    bit        calm_phase    = 1'b0;
    bit        mismatch_seen = 1'b0;
    int        send_gap      = 0;
    int        recv_stall    = 0;
    int        cycle_count   = 0;

    // ------------------------------------------------------------------
    // Command side. Valid is only lowered between transfers or during a
    // gap, so each edge assigns it once. The model is advanced at the edge
    // that completes the transfer, in the order the block accepts them.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        lfr_out_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted = advance_lru_order(s_payload);
                if (presented_row.typed) begin
                    predicted.victim_frame = presented_row.want_victim;
                    predicted.victim_valid = presented_row.want_valid;
                    predicted.empty_error  = presented_row.want_error;
                end
                victim_reports_due.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (stimulus_rows.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!calm_phase && $urandom_range(0, 99) < 15) begin
                    // This cycle is the first of a gap; send_gap holds the cycles left after it.
                    send_gap = $urandom_range(0, 17);
                    s_valid <= 1'b0;
                end else begin
                    presented_row = stimulus_rows.pop_front();
                    s_valid <= 1'b1;
                    s_payload <= '{command: presented_row.command,
                                   frame_index: presented_row.frame_index};
                    calm_phase = (stimulus_rows.size() < CALM_ITEMS);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: stalls in bursts of random length, none near the end.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 99) < 12) begin
            recv_stall = $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every result transfer is matched against the oldest outstanding report.
    always @(posedge aclk) begin
        lfr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (victim_reports_due.size() == 0) begin
                $error("result transfer with no command outstanding: %p", m_payload);
                mismatch_seen = 1'b1;
            end else begin
                want = victim_reports_due.pop_front();
                if (m_payload.victim_frame !== want.victim_frame) begin
                    $error("victim_frame expected %0d got %0d",
                           want.victim_frame, m_payload.victim_frame);
                    mismatch_seen = 1'b1;
                end
                if (m_payload.victim_valid !== want.victim_valid) begin
                    $error("victim_valid expected %0d got %0d",
                           want.victim_valid, m_payload.victim_valid);
                    mismatch_seen = 1'b1;
                end
                if (m_payload.empty_error !== want.empty_error) begin
                    $error("empty_error expected %0d got %0d",
                           want.empty_error, m_payload.empty_error);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_lru_frame_replacement: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build and end of run. The random part is cut into blocks
    // of one flavor each: hot references to a small pool of frames (lots
    // of moves from the head and the middle), wide references over all
    // frames with few evictions, and drains that empty the list and run
    // into evictions on an empty list.
    // ------------------------------------------------------------------
    initial begin
        stim_row_t  row;
        int         random_left;
        int         flavor;
        int         block_len;
        int         pool_size;
        int         evict_pct;
        logic [7:0] pool_base;

        foreach (directed_rows[i]) begin
            stimulus_rows.push_back(directed_rows[i]);
        end

        random_left = RANDOM_ITEMS;
        while (random_left > 0) begin
            flavor    = $urandom_range(0, 2);
            block_len = $urandom_range(20, 60);
            pool_base = 8'($urandom_range(0, 255));
            pool_size = $urandom_range(2, 12);
            case (flavor)
                0: evict_pct = 20;
                1: evict_pct = 8;
                default: evict_pct = 65;
            endcase
            for (int k = 0; k < block_len && random_left > 0; k++) begin
                row = '{default: '0};
                if ($urandom_range(0, 99) < evict_pct) begin
                    row.command     = CMD_EVICT;
                    row.frame_index = 8'($urandom_range(0, 255));
                end else begin
                    row.command = CMD_REFERENCE;
                    if (flavor == 1) begin
                        row.frame_index = 8'($urandom_range(0, 255));
                    end else begin
                        row.frame_index = pool_base + 8'($urandom_range(0, pool_size - 1));
                    end
                end
                stimulus_rows.push_back(row);
                random_left--;
            end
        end

        // Reset is held once, at the start of the run.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Sampled away from the rising edge so the driver and checker have settled.
        while (stimulus_rows.size() != 0 || s_valid || victim_reports_due.size() != 0) begin
            @(negedge aclk);
        end
        // A stray extra result would show up during the drain.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (!mismatch_seen && victim_reports_due.size() == 0) begin
            $display("tb_lru_frame_replacement: PASS");
        end else begin
            $display("tb_lru_frame_replacement: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/lfr_pkg.sv
rtl/core/lfr_ram.sv
rtl/core/lfr_ctrl.sv
rtl/core/lru_frame_replacement.sv
rtl/core/lfr_checker.sv
sim/tb_lru_frame_replacement.sv
